### hdl/swm_pkg.sv
// shared constants and types for the sliding window maximum block
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int DATA_WIDTH_DEF  = 16;
    localparam int CFG_WIDTH       = 7;
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RST = CFG_WIDTH'(1);

    // per-item control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/swm_in_if.sv
// sample input channel
`timescale 1ns / 1ps
`default_nettype none

interface swm_in_if #(
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

### hdl/swm_out_if.sv
// window maximum result channel
`timescale 1ns / 1ps
`default_nettype none

interface swm_out_if #(
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

### hdl/swm_cfg_if.sv
// window size register write channel
`timescale 1ns / 1ps
`default_nettype none

interface swm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [swm_pkg::CFG_WIDTH-1:0]  window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

### hdl/swm_cell.sv
// one candidate cell of the sample shift chain
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
    parameter int KW         = 7,
    parameter int INDEX      = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire swm_pkg::t_cell_ctl           i_ctl,
    input  wire logic [KW-1:0]                i_k,
    input  wire logic signed [DATA_WIDTH-1:0] i_sample,
    input  wire logic                         i_prev_vld,
    input  wire logic signed [DATA_WIDTH-1:0] i_prev_val,
    output logic                              o_vld,
    output logic signed [DATA_WIDTH-1:0]      o_val,
    output logic                              o_n_vld,
    output logic signed [DATA_WIDTH-1:0]      o_n_val
);

    logic                         r_vld;
    logic signed [DATA_WIDTH-1:0] r_val;
    logic                         expire;

    // cell index equals the age of the sample it holds after a shift
    assign expire = (32'(INDEX) >= 32'(i_k));

    always_comb begin
        if (INDEX == 0) begin
            o_n_vld = 1'b1;
            o_n_val = i_sample;
        end else begin
            // a candidate survives only while strictly above the new sample
            o_n_vld = i_prev_vld && !i_ctl.clear && !expire && (i_prev_val > i_sample);
            o_n_val = i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= o_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val <= o_n_val;
        end
    end

    assign o_vld = r_vld;
    assign o_val = r_val;

endmodule

`default_nettype wire

### hdl/swm_tree_stage.sv
// one registered level of the oldest-candidate selection tree
`timescale 1ns / 1ps
`default_nettype none

module swm_tree_stage #(
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
    parameter int NP         = 64,
    parameter int NODES      = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_slot,
    input  wire logic                         i_vld [NP],
    input  wire logic signed [DATA_WIDTH-1:0] i_val [NP],
    output logic                              o_slot,
    output logic                              o_vld [NP],
    output logic signed [DATA_WIDTH-1:0]      o_val [NP]
);

    logic                         r_slot;
    logic                         r_vld [NODES];
    logic signed [DATA_WIDTH-1:0] r_val [NODES];
    logic                         n_vld [NODES];
    logic signed [DATA_WIDTH-1:0] n_val [NODES];

    // the older valid candidate of a pair is always the larger one
    always_comb begin
        for (int j = 0; j < NODES; j++) begin
            n_vld[j] = i_vld[2*j] || i_vld[2*j+1];
            n_val[j] = i_vld[2*j+1] ? i_val[2*j+1] : i_val[2*j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 1'b0;
        end else if (i_en) begin
            r_slot <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NODES; j++) begin
                r_vld[j] <= n_vld[j];
                r_val[j] <= n_val[j];
            end
        end
    end

    assign o_slot = r_slot;

    for (genvar j = 0; j < NP; j++) begin : g_out
        if (j < NODES) begin : g_used
            assign o_vld[j] = r_vld[j];
            assign o_val[j] = r_val[j];
        end else begin : g_unused
            assign o_vld[j] = 1'b0;
            assign o_val[j] = '0;
        end
    end

endmodule

`default_nettype wire

### hdl/sliding_window_maximum.sv
// sliding window maximum top level
// Takes one signed sample per clock and, once window_size samples of the current sequence
// have arrived, returns the largest of the last window_size samples. Samples shift through a
// chain of WINDOW_MAX cells, each tagged as a candidate while it is inside the window and
// strictly above every newer sample; the oldest candidate is the maximum and is picked by a
// registered tree of log2(WINDOW_MAX) levels (at least one). An item is accepted every clock
// while the result side keeps up; a result passes through every level register of the tree
// on its way to the output. start_req clears the window before its sample enters. window_size
// 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swm_in_if.sink     i_in,
    swm_cfg_if.sink    i_cfg,
    swm_out_if.source  o_out
);

    localparam int LV = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NP = 1 << LV;
    localparam int KW = $clog2(WINDOW_MAX + 1);

    logic [swm_pkg::CFG_WIDTH-1:0] r_window_size;
    logic [KW-1:0]                 r_filled;
    logic [KW-1:0]                 n_filled;
    logic [KW-1:0]                 filled_base;
    logic [KW-1:0]                 k_eff;
    logic [31:0]                   cfg_ext;
    logic                          accept;
    logic                          has_result;
    swm_pkg::t_cell_ctl            cell_ctl;

    logic                          cell_vld [WINDOW_MAX];
    logic signed [DATA_WIDTH-1:0]  cell_val [WINDOW_MAX];
    logic                          lvl_vld  [LV+1][NP];
    logic signed [DATA_WIDTH-1:0]  lvl_val  [LV+1][NP];
    logic                          slot     [LV+1];
    logic                          en       [LV+1];

    // configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WINDOW_SIZE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_window_size <= i_cfg.window_size;
        end
    end

    assign cfg_ext = 32'(r_window_size);

    always_comb begin
        if (cfg_ext == 32'd0) begin
            k_eff = KW'(1);
        end else if (cfg_ext > 32'(WINDOW_MAX)) begin
            k_eff = KW'(WINDOW_MAX);
        end else begin
            k_eff = KW'(cfg_ext);
        end
    end

    // sample count, saturating at the window size
    assign accept      = i_in.valid && i_in.ready;
    assign filled_base = i_in.start_req ? '0 : r_filled;
    assign n_filled    = (filled_base < k_eff) ? filled_base + KW'(1) : k_eff;
    assign has_result  = (n_filled >= k_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (accept) begin
            r_filled <= n_filled;
        end
    end

    assign cell_ctl.shift = accept;
    assign cell_ctl.clear = i_in.start_req;

    // cell chain, index equals sample age
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic                         prev_vld;
        logic signed [DATA_WIDTH-1:0] prev_val;

        if (i == 0) begin : g_head
            assign prev_vld = 1'b0;
            assign prev_val = i_in.sample;
        end else begin : g_body
            assign prev_vld = cell_vld[i-1];
            assign prev_val = cell_val[i-1];
        end

        swm_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .KW         (KW),
            .INDEX      (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_k        (k_eff),
            .i_sample   (i_in.sample),
            .i_prev_vld (prev_vld),
            .i_prev_val (prev_val),
            .o_vld      (cell_vld[i]),
            .o_val      (cell_val[i]),
            .o_n_vld    (lvl_vld[0][i]),
            .o_n_val    (lvl_val[0][i])
        );
    end

    for (genvar i = WINDOW_MAX; i < NP; i++) begin : g_pad
        assign lvl_vld[0][i] = 1'b0;
        assign lvl_val[0][i] = '0;
    end

    // selection tree, each level stalls only when the one after it is full and stalled
    assign slot[0] = accept && has_result;
    assign en[0]   = en[1];
    assign en[LV]  = !slot[LV] || o_out.ready;

    for (genvar l = 1; l < LV; l++) begin : g_en
        assign en[l] = !slot[l] || en[l+1];
    end

    for (genvar l = 1; l <= LV; l++) begin : g_lvl
        swm_tree_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .NP         (NP),
            .NODES      (NP >> l)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[l]),
            .i_slot  (slot[l-1]),
            .i_vld   (lvl_vld[l-1]),
            .i_val   (lvl_val[l-1]),
            .o_slot  (slot[l]),
            .o_vld   (lvl_vld[l]),
            .o_val   (lvl_val[l])
        );
    end

    assign i_in.ready       = en[0];
    assign o_out.valid      = slot[LV];
    assign o_out.window_max = lvl_val[LV][0];

    // the sample count never passes the largest window
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= KW'(WINDOW_MAX))
        else $error("sample count above window capacity");

    // the newest sample is always a candidate after it enters
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> cell_vld[0])
        else $error("newest sample not held as a candidate");

    // a start item leaves exactly one sample counted
    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.start_req |=> r_filled == KW'(1))
        else $error("start item did not restart the sample count");

    // a result entering the tree is held by the first level
    a_tree_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && has_result |=> slot[1])
        else $error("result lost on entry to selection tree");

endmodule

`default_nettype wire

### tb/sliding_window_maximum_tb.sv
// testbench for the sliding window maximum block: directed table, random phases, running predictor
`timescale 1ns / 1ps

module sliding_window_maximum_tb;

    localparam int DW              = swm_pkg::DATA_WIDTH_DEF;
    localparam int WMAX            = swm_pkg::WINDOW_MAX_DEF;
    localparam int CW              = swm_pkg::CFG_WIDTH;
    localparam int POS_W           = $clog2(2 * WMAX);
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 250;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int TIMEOUT_NS      = 5_000_000;

    typedef enum logic {ROW_ITEM, ROW_WIN} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CW-1:0]         win;
        logic signed [DW-1:0]  sample;
        logic                  start;
        logic                  fixed;
        logic signed [DW-1:0]  max_val;
    } t_stim_row;

    typedef struct packed {
        logic                  fixed;
        logic signed [DW-1:0]  max_val;
    } t_typed_note;

    localparam t_stim_row DIRECTED_ROWS [30] = '{
        // reset window of one: every sample is its own maximum
        '{ROW_ITEM, 7'd0,   16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF},
        '{ROW_ITEM, 7'd0,   16'sh8000, 1'b0, 1'b1, 16'sh8000},
        '{ROW_ITEM, 7'd0,   16'sh0000, 1'b1, 1'b1, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'shFFFF, 1'b0, 1'b1, 16'shFFFF},
        // zero size acts as one
        '{ROW_WIN,  7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0005, 1'b1, 1'b1, 16'sh0005},
        '{ROW_ITEM, 7'd0,   16'shFFF9, 1'b0, 1'b1, 16'shFFF9},
        // equal samples, then the old maximum expiring
        '{ROW_WIN,  7'd3,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh000A, 1'b1, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh000A, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0003, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0002, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0001, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh8000, 1'b0, 1'b1, 16'sh8000},
        // smaller window mid-sequence gives a result at once
        '{ROW_WIN,  7'd2,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF},
        '{ROW_ITEM, 7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        // larger window mid-sequence waits until full
        '{ROW_WIN,  7'd5,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh1234, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh4321, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
        // oversize saturates to the largest window
        '{ROW_WIN,  7'd127, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_WIN,  7'd64,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'sh0001, 1'b0, 1'b0, 16'sh0000},
        '{ROW_ITEM, 7'd0,   16'shFFFF, 1'b1, 1'b0, 16'sh0000}
    };

    localparam logic [CW-1:0] PHASE_WIN [9] = '{
        7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd7, 7'd33, 7'd3
    };

    logic i_clk;
    logic i_rst_n;

    swm_in_if  #(.DATA_WIDTH(DW)) in_if ();
    swm_out_if #(.DATA_WIDTH(DW)) out_if ();
    swm_cfg_if                    cfg_if ();

    sliding_window_maximum #(
        .WINDOW_MAX (WMAX),
        .DATA_WIDTH (DW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // predictor state: candidates oldest first, positions wrap at twice the window limit
    logic signed [DW-1:0]   cand_val [WMAX];
    logic [POS_W-1:0]       cand_pos [WMAX];
    int                     cand_count = 0;
    logic [POS_W-1:0]       pos_ctr = '0;
    int                     filled = 0;
    logic [CW-1:0]          window_size_reg = swm_pkg::WINDOW_SIZE_RST;

    t_typed_note            typed_max_q [$];
    logic signed [DW-1:0]   expected_max_q [$];
    int                     fail_count = 0;

    int                     src_idle_pct = 12;
    int                     snk_idle_pct = 69;
    logic                   hold_active = 1'b0;
    event                   hold_go;

    function automatic bit advance_window(input logic signed [DW-1:0] s, input logic st,
                                          output logic signed [DW-1:0] mx);
        int k;
        int drop;
        logic [POS_W-1:0] age;
        k = int'(window_size_reg);
        if (k < 1) k = 1;
        if (k > WMAX) k = WMAX;
        if (st) begin
            cand_count = 0;
            pos_ctr = '0;
            filled = 0;
        end
        for (drop = 0; drop < cand_count; drop++) begin
            age = pos_ctr - cand_pos[drop];
            if (int'(age) < k) break;
        end
        for (int i = 0; i + drop < cand_count; i++) begin
            cand_val[i] = cand_val[i + drop];
            cand_pos[i] = cand_pos[i + drop];
        end
        cand_count -= drop;
        // an older candidate equal to the new sample goes too
        while (cand_count > 0 && cand_val[cand_count - 1] <= s) cand_count--;
        if (cand_count < WMAX) begin
            cand_val[cand_count] = s;
            cand_pos[cand_count] = pos_ctr;
            cand_count++;
        end
        pos_ctr++;
        if (filled < k) filled++;
        if (filled > k) filled = k;
        mx = cand_val[0];
        return filled >= k;
    endfunction

    function automatic logic signed [DW-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return DW'(int'($urandom_range(8)) - 4);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [DW-1:0] s, input logic st,
                               input logic fixed, input logic signed [DW-1:0] fixed_max);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample    <= s;
        in_if.start_req <= st;
        typed_max_q.insert(typed_max_q.size(), t_typed_note'{fixed, fixed_max});
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_max_q.size() != 0);
        // items that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CW-1:0] ws);
        drain_results();
        cfg_if.valid       <= 1'b1;
        cfg_if.window_size <= ws;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sliding_window_maximum_tb failed");
        $finish;
    end

    // receiver side, with a long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= !hold_active && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        forever begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        logic signed [DW-1:0] predicted;
        logic signed [DW-1:0] want;
        t_typed_note          note;
        if (cfg_if.valid && cfg_if.ready) window_size_reg = cfg_if.window_size;
        if (in_if.valid && in_if.ready) begin
            note = typed_max_q[0];
            typed_max_q.delete(0);
            if (advance_window(in_if.sample, in_if.start_req, predicted))
                expected_max_q.insert(expected_max_q.size(),
                                      note.fixed ? note.max_val : predicted);
        end
        if (out_if.valid && out_if.ready) begin
            if (expected_max_q.size() == 0) begin
                $error("window_max: expected none, got %0d", out_if.window_max);
                fail_count++;
            end else begin
                want = expected_max_q[0];
                expected_max_q.delete(0);
                if (out_if.window_max !== want) begin
                    $error("window_max: expected %0d, got %0d", want, out_if.window_max);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [CW-1:0] win;
        int            k;
        logic          st;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.sample       = '0;
        in_if.start_req    = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.window_size = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_WIN)
                set_window(DIRECTED_ROWS[r].win);
            else
                send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].start,
                            DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].max_val);
        end

        for (int p = 0; p < PHASES; p++) begin
            win = (p < $size(PHASE_WIN)) ? PHASE_WIN[p] : CW'($urandom_range(127));
            set_window(win);
            if (p == 4) begin
                src_idle_pct = 69;
                snk_idle_pct <= 12;
            end else if (p == 8) begin
                src_idle_pct = 0;
                snk_idle_pct <= 0;
            end
            // long receiver stall so the block backs up into its input
            if (p == 0 || p == 8) -> hold_go;
            k = (win == 0) ? 1 : ((int'(win) > WMAX) ? WMAX : int'(win));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                st = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(3 * k + 7) == 0);
                send_sample(pick_sample(), st, 1'b0, '0);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("sliding_window_maximum_tb passed");
        else
            $display("sliding_window_maximum_tb failed");
        $finish;
    end

endmodule
